// ===== rtl/min_stack_positional_assert.svh =====
// assertion macros shared by the min stack rtl
`ifndef MIN_STACK_POSITIONAL_ASSERT_SVH
`define MIN_STACK_POSITIONAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MSTK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSTK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSTK_ASSERT(lbl, prop, msg)
`define MSTK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/mstk_pkg.sv =====
// types and constants shared by the min stack modules
package mstk_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam func_t FN_PUSH   = 3'd0;
    localparam func_t FN_POP    = 3'd1;
    localparam func_t FN_INSERT = 3'd2;
    localparam func_t FN_REMOVE = 3'd3;
    localparam func_t FN_QUERY  = 3'd4;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_OVER   = 2'd1;
    localparam status_t ST_UNDER  = 2'd2;
    localparam status_t ST_BADPOS = 2'd3;

    typedef struct packed {
        logic apply;
        logic load;
    } mstk_cmd_t;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] val;
    } mstk_node_t;

endpackage

// ===== rtl/mstk_tree.sv =====
// registered selection tree returning the valid leaf with the smallest signed value
module mstk_tree #(
    parameter int LEAVES = 64
) (
    input  logic               clk,
    input  mstk_pkg::mstk_node_t leaf [LEAVES],
    output mstk_pkg::mstk_node_t root
);
    import mstk_pkg::*;

    localparam int LVLS = $clog2(LEAVES);
    localparam int P2   = 1 << LVLS;

    mstk_node_t node [LVLS+1][P2];

    function automatic mstk_node_t pick(input mstk_node_t a, input mstk_node_t b);
        if (a.vld && (!b.vld || ($signed(a.val) <= $signed(b.val))))
        begin
            return a;
        end
        return b;
    endfunction

    for (genvar j = 0; j < P2; j++)
    begin : g_leaf
        if (j < LEAVES)
        begin : g_real
            assign node[0][j] = leaf[j];
        end
        else
        begin : g_pad
            assign node[0][j] = '0;
        end
    end

    // a register after every second level and after the last
    for (genvar k = 1; k <= LVLS; k++)
    begin : g_lvl
        localparam int W = P2 >> k;
        if ((k % 2 == 0) || (k == LVLS))
        begin : g_reg
            always_ff @(posedge clk)
            begin
                for (int j = 0; j < W; j++)
                begin
                    node[k][j] <= pick(node[k-1][2*j], node[k-1][2*j+1]);
                end
                for (int j = W; j < P2; j++)
                begin
                    node[k][j] <= '0;
                end
            end
        end
        else
        begin : g_comb
            always_comb
            begin
                for (int j = 0; j < W; j++)
                begin
                    node[k][j] = pick(node[k-1][2*j], node[k-1][2*j+1]);
                end
                for (int j = W; j < P2; j++)
                begin
                    node[k][j] = '0;
                end
            end
        end
    end

    assign root = node[LVLS][0];

endmodule

// ===== rtl/mstk_ctrl.sv =====
// controller state machine sequencing accept, tree settle and result load
`include "min_stack_positional_assert.svh"
module mstk_ctrl #(
    parameter int TREE_LAT = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output mstk_pkg::mstk_cmd_t cmd
);
    import mstk_pkg::*;

    localparam int CNT_W = $clog2(TREE_LAT + 1);

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] wait_cnt_reg, wait_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             settled;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign settled  = (wait_cnt_reg == CNT_W'(TREE_LAT));

    always_comb
    begin
        cmd.apply      = s_tvalid && s_tready;
        cmd.load       = (state_reg == S_WAIT) && settled && (!out_valid_reg || m_tready);
        state_next     = state_reg;
        wait_cnt_next  = wait_cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.apply)
                begin
                    state_next    = S_WAIT;
                    wait_cnt_next = '0;
                end
            end
            S_WAIT:
            begin
                if (cmd.load)
                begin
                    state_next = S_IDLE;
                end
                else if (!settled)
                begin
                    wait_cnt_next = wait_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_cnt_reg  <= wait_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MSTK_ASSERT_ALWAYS(a_apply_idle, cmd.apply |-> (state_reg == S_IDLE), "apply outside idle")
    `MSTK_ASSERT(a_load_free, cmd.load |-> (!out_valid_reg || m_tready), "result overwritten")
    `MSTK_ASSERT(a_wait_start, cmd.apply |=> ((state_reg == S_WAIT) && (wait_cnt_reg == '0)), "wait not started")

endmodule

// ===== rtl/mstk_dp.sv =====
// datapath: shifting entry cells, count, status, min and top trees, result register
`include "min_stack_positional_assert.svh"
module mstk_dp #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mstk_pkg::mstk_cmd_t           cmd,
    input  mstk_pkg::func_t               func,
    input  logic [mstk_pkg::DATA_W-1:0]   value,
    input  logic [CW-1:0]                 position,
    output logic [mstk_pkg::DATA_W-1:0]   top_value,
    output logic [mstk_pkg::DATA_W-1:0]   min_value,
    output logic [CW-1:0]                 count,
    output logic                          is_empty,
    output mstk_pkg::status_t             status
);
    import mstk_pkg::*;

    logic [DATA_W-1:0] cell_reg [DEPTH];
    logic [DATA_W-1:0] below_val [DEPTH];
    logic [DATA_W-1:0] above_val [DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    status_t           status_reg, status_next;
    logic              full, empty, do_ins, do_rem;
    logic [CW-1:0]     ins_pos, rem_pos;
    mstk_node_t        min_leaf [DEPTH];
    mstk_node_t        top_leaf [DEPTH];
    mstk_node_t        min_root, top_root;

    logic [DATA_W-1:0] out_top_reg, out_min_reg;
    logic [CW-1:0]     out_count_reg;
    logic              out_empty_reg;
    status_t           out_status_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        status_next = ST_OK;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        ins_pos     = count_reg;
        rem_pos     = count_reg - 1'b1;
        unique case (func)
            FN_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            FN_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_OVER;
                end
                else if (position > count_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    do_ins  = 1'b1;
                    ins_pos = position;
                end
            end
            FN_POP:
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    do_rem = 1'b1;
                end
            end
            FN_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_UNDER;
                end
                else if (position >= count_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    do_rem  = 1'b1;
                    rem_pos = position;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // neighbour taps for the shift up and shift down moves
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tap
        if (i == 0)
        begin : g_bot
            assign below_val[i] = '0;
        end
        else
        begin : g_below
            assign below_val[i] = cell_reg[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_top
            assign above_val[i] = '0;
        end
        else
        begin : g_above
            assign above_val[i] = cell_reg[i+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_ins)
                begin
                    if (CW'(i) == ins_pos)
                    begin
                        cell_reg[i] <= value;
                    end
                    else if (CW'(i) > ins_pos)
                    begin
                        cell_reg[i] <= below_val[i];
                    end
                end
                else if (do_rem && (CW'(i) >= rem_pos))
                begin
                    cell_reg[i] <= above_val[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else if (cmd.apply)
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            min_leaf[i].vld = (CW'(i) < count_reg);
            min_leaf[i].val = cell_reg[i];
            top_leaf[i].vld = (CW'(i + 1) == count_reg);
            top_leaf[i].val = cell_reg[i];
        end
    end

    mstk_tree #(
        .LEAVES (DEPTH)
    ) u_min_tree (
        .clk  (clk),
        .leaf (min_leaf),
        .root (min_root)
    );

    mstk_tree #(
        .LEAVES (DEPTH)
    ) u_top_tree (
        .clk  (clk),
        .leaf (top_leaf),
        .root (top_root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_top_reg    <= top_root.vld ? top_root.val : '0;
            out_min_reg    <= min_root.vld ? min_root.val : '0;
            out_count_reg  <= count_reg;
            out_empty_reg  <= empty;
            out_status_reg <= status_reg;
        end
    end

    assign top_value = out_top_reg;
    assign min_value = out_min_reg;
    assign count     = out_count_reg;
    assign is_empty  = out_empty_reg;
    assign status    = out_status_reg;

    `MSTK_ASSERT(a_count_range, count_reg <= CW'(DEPTH), "count beyond depth")
    `MSTK_ASSERT(a_fail_hold, (cmd.apply && (status_next != ST_OK)) |=> $stable(count_reg), "failed op moved count")
    `MSTK_ASSERT(a_ins_grow, (cmd.apply && do_ins) |=> (count_reg == CW'($past(count_reg) + 1'b1)), "insert did not grow count")

endmodule

// ===== rtl/min_stack_positional.sv =====
// top level of the bounded min stack with positional insert and remove
// A bounded stack of signed 32-bit entries (entry 0 at the bottom) that reports
// top, minimum, count, empty flag and status after every operation: push, pop,
// insert at a position, remove at a position, or query (unused codes act as
// query). One transaction in gives one transaction out. An operation is accepted,
// then waits while the registered minimum and top-select trees over the DEPTH
// entry cells settle, and then its result is loaded; the next operation is
// accepted only after that result load. A new transaction is taken while the
// previous result still waits in the output register. The store starts empty
// after reset.
module min_stack_positional #(
    parameter int  DEPTH  = 64,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IN_W   = mstk_pkg::FUNC_W + mstk_pkg::DATA_W + CW,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 2 * mstk_pkg::DATA_W + CW + 1 + mstk_pkg::STAT_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // func, value, position
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata    // top_value, min_value, count, is_empty, status
);
    import mstk_pkg::*;

    localparam int TREE_LAT = ($clog2(DEPTH) + 1) / 2;

    mstk_cmd_t         cmd;
    func_t             func;
    logic [DATA_W-1:0] value;
    logic [CW-1:0]     position;
    logic [DATA_W-1:0] top_value, min_value;
    logic [CW-1:0]     count;
    logic              is_empty;
    status_t           status;

    assign func     = s_tdata[FUNC_W-1:0];
    assign value    = s_tdata[FUNC_W +: DATA_W];
    assign position = s_tdata[FUNC_W + DATA_W +: CW];

    mstk_ctrl #(
        .TREE_LAT (TREE_LAT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mstk_dp #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .func      (func),
        .value     (value),
        .position  (position),
        .top_value (top_value),
        .min_value (min_value),
        .count     (count),
        .is_empty  (is_empty),
        .status    (status)
    );

    assign m_tdata = OUT_TW'({status, is_empty, count, min_value, top_value});

endmodule
